// ===== rtl/mrts_pkg.sv =====
package mrts_pkg;

   localparam int NUM_DIV        = 7;
   localparam int PERIOD_W       = 16;
   localparam int DIV_IDX_W      = 3;
   localparam int BLINK_CHANNELS = 8;
   localparam int BLINK_W        = 8;
   localparam int CLOCK_W        = 6;
   localparam int COUNT_W        = 32;
   localparam int EVENT_W        = 8;

   localparam logic [CLOCK_W-1:0] CLOCK_LAST = CLOCK_W'(59);

   // only the low BLINK_CHANNELS bits of the blink word are live
   localparam logic [BLINK_W-1:0] BLINK_MASK =
      (BLINK_CHANNELS >= BLINK_W) ? {BLINK_W{1'b1}}
                                  : BLINK_W'((1 << BLINK_CHANNELS) - 1);

   // divider / period register indexes
   typedef enum logic [DIV_IDX_W-1:0] {
      DIV_SECOND  = 3'd0,
      DIV_REPORT  = 3'd1,
      DIV_DISPLAY = 3'd2,
      DIV_BLINK   = 3'd3,
      DIV_ADC     = 3'd4,
      DIV_METER   = 3'd5,
      DIV_CHECK   = 3'd6
   } div_sel_type;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET [NUM_DIV] = '{
      16'd1000, 16'd10000, 16'd3000, 16'd200, 16'd800, 16'd50, 16'd5000
   };

   // bit positions in event_strobes
   localparam int EV_SECOND  = 0;
   localparam int EV_MINUTE  = 1;
   localparam int EV_HOUR    = 2;
   localparam int EV_REPORT  = 3;
   localparam int EV_DISPLAY = 4;
   localparam int EV_ADC     = 5;
   localparam int EV_METER   = 6;
   localparam int EV_CHECK   = 7;

   typedef struct packed {
      logic second;
      logic report;
      logic display;
      logic blink;
      logic adc;
      logic meter;
      logic check;
   } tick_type;

   typedef struct packed {
      logic [EVENT_W-1:0] event_strobes;
      logic [CLOCK_W-1:0] seconds_now;
      logic [CLOCK_W-1:0] minutes_now;
      logic [BLINK_W-1:0] blink_bits;
      logic [COUNT_W-1:0] power_ticks;
      logic [COUNT_W-1:0] tx_ticks;
   } rsp_word_type;

endpackage

// ===== rtl/mrts_req_if.sv =====
interface mrts_req_if;
   import mrts_pkg::*;

   logic               valid;
   logic               ready;
   logic [BLINK_W-1:0] blink_modes;
   logic               power_count_enable;
   logic               tx_count_enable;

   modport source (output valid, output blink_modes, output power_count_enable,
                   output tx_count_enable, input ready);
   modport sink   (input valid, input blink_modes, input power_count_enable,
                   input tx_count_enable, output ready);
endinterface

// ===== rtl/mrts_rsp_if.sv =====
interface mrts_rsp_if;
   import mrts_pkg::*;

   logic               valid;
   logic               ready;
   logic [EVENT_W-1:0] event_strobes;
   logic [CLOCK_W-1:0] seconds_now;
   logic [CLOCK_W-1:0] minutes_now;
   logic [BLINK_W-1:0] blink_bits;
   logic [COUNT_W-1:0] power_ticks;
   logic [COUNT_W-1:0] tx_ticks;

   modport source (output valid, output event_strobes, output seconds_now,
                   output minutes_now, output blink_bits, output power_ticks,
                   output tx_ticks, input ready);
   modport sink   (input valid, input event_strobes, input seconds_now,
                   input minutes_now, input blink_bits, input power_ticks,
                   input tx_ticks, output ready);
endinterface

// ===== rtl/mrts_dividers.sv =====
module mrts_dividers (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [mrts_pkg::DIV_IDX_W-1:0]   csr_index,
   input  logic [mrts_pkg::PERIOD_W-1:0]    csr_wdata,
   input  logic                             advance,
   output mrts_pkg::tick_type               tick
);
   import mrts_pkg::*;

   logic [PERIOD_W-1:0] period_ff [NUM_DIV];
   logic [PERIOD_W-1:0] count_ff  [NUM_DIV];
   logic [PERIOD_W-1:0] count_in  [NUM_DIV];
   logic [PERIOD_W:0]   count_inc [NUM_DIV];
   logic [NUM_DIV-1:0]  hit;

   // strobe when count+1 reaches the period; a zero period behaves as one
   always_comb begin
      for (int k = 0; k < NUM_DIV; k++) begin
         count_inc[k] = (PERIOD_W+1)'(count_ff[k]) + (PERIOD_W+1)'(1);
         hit[k]       = (period_ff[k] == '0) ||
                        (count_inc[k] >= (PERIOD_W+1)'(period_ff[k]));
         count_in[k]  = hit[k] ? '0 : count_inc[k][PERIOD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_DIV; k++) begin
            period_ff[k] <= PERIOD_RESET[k];
            count_ff[k]  <= '0;
         end
      end else begin
         for (int k = 0; k < NUM_DIV; k++) begin
            if (csr_we && csr_index == DIV_IDX_W'(k)) begin
               period_ff[k] <= csr_wdata;
            end
            if (advance) begin
               count_ff[k] <= count_in[k];
            end
         end
      end
   end

   assign tick.second  = hit[DIV_SECOND];
   assign tick.report  = hit[DIV_REPORT];
   assign tick.display = hit[DIV_DISPLAY];
   assign tick.blink   = hit[DIV_BLINK];
   assign tick.adc     = hit[DIV_ADC];
   assign tick.meter   = hit[DIV_METER];
   assign tick.check   = hit[DIV_CHECK];

endmodule

// ===== rtl/mrts_timekeep.sv =====
module mrts_timekeep (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  mrts_pkg::tick_type             tick,
   input  logic [mrts_pkg::BLINK_W-1:0]   blink_modes,
   input  logic                           power_count_enable,
   input  logic                           tx_count_enable,
   output mrts_pkg::rsp_word_type         result
);
   import mrts_pkg::*;

   logic [CLOCK_W-1:0] seconds_ff, seconds_in;
   logic [CLOCK_W-1:0] minutes_ff, minutes_in;
   logic [BLINK_W-1:0] blink_ff, blink_in;
   logic [COUNT_W-1:0] power_ff, power_in;
   logic [COUNT_W-1:0] tx_ff, tx_in;
   logic               sec_wrap, min_wrap;
   logic [EVENT_W-1:0] strobes;

   always_comb begin
      sec_wrap = tick.second && (seconds_ff >= CLOCK_LAST);
      min_wrap = sec_wrap && (minutes_ff >= CLOCK_LAST);

      if (!tick.second) seconds_in = seconds_ff;
      else if (sec_wrap) seconds_in = '0;
      else seconds_in = seconds_ff + CLOCK_W'(1);

      if (!sec_wrap) minutes_in = minutes_ff;
      else if (min_wrap) minutes_in = '0;
      else minutes_in = minutes_ff + CLOCK_W'(1);

      // set mode bit toggles, clear mode bit forces off
      blink_in = tick.blink ? (blink_modes & BLINK_MASK & ~blink_ff) : blink_ff;

      power_in = power_ff + COUNT_W'(power_count_enable);
      tx_in    = tx_ff + COUNT_W'(tx_count_enable);

      strobes             = '0;
      strobes[EV_SECOND]  = tick.second;
      strobes[EV_MINUTE]  = sec_wrap;
      strobes[EV_HOUR]    = min_wrap;
      strobes[EV_REPORT]  = tick.report;
      strobes[EV_DISPLAY] = tick.display;
      strobes[EV_ADC]     = tick.adc;
      strobes[EV_METER]   = tick.meter;
      strobes[EV_CHECK]   = tick.check;

      result.event_strobes = strobes;
      result.seconds_now   = seconds_in;
      result.minutes_now   = minutes_in;
      result.blink_bits    = blink_in;
      result.power_ticks   = power_in;
      result.tx_ticks      = tx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seconds_ff <= '0;
         minutes_ff <= '0;
         blink_ff   <= '0;
         power_ff   <= '0;
         tx_ff      <= '0;
      end else if (advance) begin
         seconds_ff <= seconds_in;
         minutes_ff <= minutes_in;
         blink_ff   <= blink_in;
         power_ff   <= power_in;
         tx_ff      <= tx_in;
      end
   end

endmodule

// ===== rtl/multi_rate_tick_scheduler_unit.sv =====
// channel | dir | handshake            | word
// req_if  | in  | valid/ready          | blink_modes, power_count_enable, tx_count_enable
// rsp_if  | out | valid/ready          | event_strobes, seconds/minutes, blink_bits, counters
// csr_*   | in  | csr_we, no wait      | csr_index selects a period, csr_wdata the value
//
// One tick word per cycle while req_if.ready is high; each result is registered.
// The dividers and clock update in one pass between the request and the output register.
// Reset (synchronous) restores the default periods and clears all counts and the clock.
// Output register plus one skid entry: req_if.ready only drops when both hold a word.
module multi_rate_tick_scheduler_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [mrts_pkg::DIV_IDX_W-1:0] csr_index,
   input  logic [mrts_pkg::PERIOD_W-1:0]  csr_wdata,
   mrts_req_if.sink                       req_if,
   mrts_rsp_if.source                     rsp_if
);
   import mrts_pkg::*;

   tick_type     tick;
   rsp_word_type result;
   rsp_word_type out_ff, skid_ff;
   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   logic         accept, take;
   logic         load_out, load_skid, out_from_skid;

   assign req_if.ready = !skid_valid_ff;
   assign accept       = req_if.valid && !skid_valid_ff;
   assign take         = out_valid_ff && rsp_if.ready;

   mrts_dividers u_dividers (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .advance   (accept),
      .tick      (tick)
   );

   mrts_timekeep u_timekeep (
      .clock              (clock),
      .reset              (reset),
      .advance            (accept),
      .tick               (tick),
      .blink_modes        (req_if.blink_modes),
      .power_count_enable (req_if.power_count_enable),
      .tx_count_enable    (req_if.tx_count_enable),
      .result             (result)
   );

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      load_out      = 1'b0;
      load_skid     = 1'b0;
      out_from_skid = 1'b0;
      if (take) begin
         if (skid_valid_ff) begin
            out_from_skid = 1'b1;
            load_out      = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = accept;
            load_out     = accept;
         end
      end else if (!out_valid_ff) begin
         out_valid_in = accept;
         load_out     = accept;
      end else if (accept) begin
         load_skid     = 1'b1;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_ff <= out_from_skid ? skid_ff : result;
      end
      if (load_skid) begin
         skid_ff <= result;
      end
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.event_strobes = out_ff.event_strobes;
   assign rsp_if.seconds_now   = out_ff.seconds_now;
   assign rsp_if.minutes_now   = out_ff.minutes_now;
   assign rsp_if.blink_bits    = out_ff.blink_bits;
   assign rsp_if.power_ticks   = out_ff.power_ticks;
   assign rsp_if.tx_ticks      = out_ff.tx_ticks;

   // skid entry only fills behind a held output word
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word without output word");

   a_minute_on_wrap: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.event_strobes[EV_MINUTE] |->
         out_ff.event_strobes[EV_SECOND] && out_ff.seconds_now == '0)
      else $error("minute strobe without seconds wrap");

   a_hour_on_wrap: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.event_strobes[EV_HOUR] |->
         out_ff.event_strobes[EV_MINUTE] && out_ff.minutes_now == '0)
      else $error("hour strobe without minutes wrap");

   a_word_loaded_on_accept: assert property (@(posedge clock) disable iff (reset)
      accept && !out_valid_ff |=> out_valid_ff)
      else $error("accepted word did not reach output register");

endmodule
